// ===== rtl/qat_pkg.sv =====
`timescale 1ns / 1ps

package qat_pkg;

    localparam int ByteW = 8;
    localparam int CountW = 8;

    localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
    localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
    localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
    localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
    localparam logic [ByteW-1:0] CH_LF     = 8'h0A;
    localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
    localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
    localparam logic [ByteW-1:0] CH_LOW_N  = 8'h6E;
    localparam logic [ByteW-1:0] CH_LOW_R  = 8'h72;
    localparam logic [ByteW-1:0] CH_LOW_T  = 8'h74;

    localparam logic [CountW-1:0] MAX_ARGS_RESET = 8'd64;

    typedef enum logic [3:0] {
        MODE_SEARCH = 4'b0001,
        MODE_PLAIN  = 4'b0010,
        MODE_DOUBLE = 4'b0100,
        MODE_SINGLE = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              esc;
        logic [CountW-1:0] count;
        logic              ovf;
    } parse_state_t;

    typedef struct packed {
        logic              starts_arg;
        logic              has_byte;
        logic [ByteW-1:0]  out_byte;
        logic              ends_arg;
        logic [CountW-1:0] arg_number;
        logic              done_res;
        logic              overflow;
    } result_t;

    function automatic logic [ByteW-1:0] map_escape(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] r;
        r = c;
        if (c == CH_LOW_N) r = CH_LF;
        else if (c == CH_LOW_R) r = CH_CR;
        else if (c == CH_LOW_T) r = CH_TAB;
        return r;
    endfunction

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

// ===== rtl/qat_parse.sv =====
`timescale 1ns / 1ps

module qat_parse (
    input  logic [7:0]            ch,
    input  logic [7:0]            max_args,
    input  qat_pkg::parse_state_t cur,
    output logic                  emit,
    output qat_pkg::result_t      res,
    output qat_pkg::parse_state_t nxt
);
    import qat_pkg::*;

    logic             start, keep, fin, done, ovf_now, opens;
    logic [ByteW-1:0] kbyte;
    mode_t            next_mode;

    always_comb begin
        start     = 1'b0;
        keep      = 1'b0;
        fin       = 1'b0;
        done      = 1'b0;
        ovf_now   = 1'b0;
        opens     = 1'b0;
        kbyte     = '0;
        next_mode = cur.mode;
        nxt       = cur;

        if (ch == CH_NUL) begin
            done = 1'b1;
            fin  = (cur.mode != MODE_SEARCH);
        end else if (cur.ovf) begin
            // rest of the string is dropped quietly
        end else if (cur.esc) begin
            nxt.esc = 1'b0;
            keep    = 1'b1;
            kbyte   = map_escape(ch);
        end else begin
            if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
                unique case (cur.mode)
                    MODE_SEARCH: begin
                        opens     = 1'b1;
                        next_mode = (ch == CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                    end
                    MODE_PLAIN: begin
                        next_mode = (ch == CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                    end
                    MODE_SINGLE: begin
                        if (ch == CH_SQUOTE) next_mode = MODE_PLAIN;
                        else begin
                            keep  = 1'b1;
                            kbyte = ch;
                        end
                    end
                    MODE_DOUBLE: begin
                        if (ch == CH_DQUOTE) next_mode = MODE_PLAIN;
                        else begin
                            keep  = 1'b1;
                            kbyte = ch;
                        end
                    end
                    default: ;
                endcase
            end else if (is_blank(ch)) begin
                if (cur.mode == MODE_PLAIN) begin
                    fin       = 1'b1;
                    next_mode = MODE_SEARCH;
                end else if (cur.mode != MODE_SEARCH) begin
                    keep  = 1'b1;
                    kbyte = ch;
                end
            end else if (ch == CH_BSLASH) begin
                if (cur.mode == MODE_SEARCH) begin
                    opens     = 1'b1;
                    next_mode = MODE_PLAIN;
                end
            end else begin
                if (cur.mode == MODE_SEARCH) begin
                    opens     = 1'b1;
                    next_mode = MODE_PLAIN;
                end
                keep  = 1'b1;
                kbyte = ch;
            end

            if (opens && (cur.count >= max_args)) begin
                nxt.ovf = 1'b1;
                ovf_now = 1'b1;
                keep    = 1'b0;
            end else begin
                if (opens) begin
                    start     = 1'b1;
                    nxt.count = cur.count + CountW'(1);
                end
                nxt.mode = next_mode;
                if (ch == CH_BSLASH) nxt.esc = 1'b1;
            end
        end

        emit = start | keep | fin | done | ovf_now;

        res.starts_arg = start;
        res.has_byte   = keep;
        res.out_byte   = keep ? kbyte : '0;
        res.ends_arg   = fin;
        res.arg_number = nxt.count;
        res.done_res   = done;
        res.overflow   = nxt.ovf;

        if (done) begin
            nxt.mode  = MODE_SEARCH;
            nxt.esc   = 1'b0;
            nxt.count = '0;
            nxt.ovf   = 1'b0;
        end
    end

endmodule

// ===== rtl/quoted_argument_tokenizer.sv =====
`timescale 1ns / 1ps

// A byte in the input register is decoded and its result registered onto m_* when the
// result slot is empty or being drained; quiet bytes give no transaction.
// Throughput: one byte per cycle while m_tready is high; a result held by a low
// m_tready stalls s_tready as soon as the input register is also full.
// Reset (aresetn low, synchronous): search mode, no escape, zero words,
// overflow cleared, max_args back to 64, both registers empty.
module quoted_argument_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] arg_number
    output logic [3:0]  m_tuser,   // [0] starts_arg, [1] has_byte, [2] ends_arg, [3] overflow
    output logic        m_tlast,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // max_args
);
    import qat_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_ch_reg;
    parse_state_t st_reg, st_next;
    logic         out_valid_reg;
    result_t      out_res_reg;
    logic [7:0]   max_args_reg;

    logic    adv;
    logic    emit;
    result_t res;

    qat_parse u_parse (
        .ch       (in_ch_reg),
        .max_args (max_args_reg),
        .cur      (st_reg),
        .emit     (emit),
        .res      (res),
        .nxt      (st_next)
    );

    // held byte moves on when the result slot is empty or being drained
    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg.mode   <= MODE_SEARCH;
            st_reg.esc    <= 1'b0;
            st_reg.count  <= '0;
            st_reg.ovf    <= 1'b0;
            max_args_reg  <= MAX_ARGS_RESET;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (adv) begin
                st_reg        <= st_next;
                out_valid_reg <= emit;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) max_args_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) in_ch_reg <= s_tdata;
        if (adv && emit) out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.arg_number, out_res_reg.out_byte};
    assign m_tuser  = {out_res_reg.overflow, out_res_reg.ends_arg,
                       out_res_reg.has_byte, out_res_reg.starts_arg};
    assign m_tlast  = out_res_reg.done_res;

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_ch_reg == CH_NUL) |=>
            (st_reg.mode == MODE_SEARCH && st_reg.count == '0 && !st_reg.ovf && !st_reg.esc))
        else $error("string end did not clear parser state");

    a_esc_in_word: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.esc |-> (st_reg.mode != MODE_SEARCH))
        else $error("escape pending outside a word");

    a_no_start_after_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> !m_tuser[3])
        else $error("word started after overflow");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[7:0] == 8'h00))
        else $error("out_byte nonzero without a kept byte");

    a_quiet_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !emit) |=> !m_tvalid)
        else $error("quiet byte produced a transaction");

endmodule

// ===== tb/quoted_argument_tokenizer_tb.sv =====
`timescale 1ns / 1ps

module quoted_argument_tokenizer_tb;

    import qat_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [7:0] out_byte, [15:8] arg_number
    logic [3:0]  m_tuser;    // [0] starts_arg, [1] has_byte, [2] ends_arg, [3] overflow
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // Tokenizer state as the testbench sees it
    mode_t       parse_mode = MODE_SEARCH;
    logic        esc_armed = 1'b0;
    logic [7:0]  word_cnt = '0;
    logic        string_ovf = 1'b0;
    logic [7:0]  max_words = MAX_ARGS_RESET;

    logic [7:0]  cmd_bytes_q[$];
    result_t     split_results_q[$];

    int errors = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int results_checked = 0;
    int starts_seen = 0;
    int overflows_seen = 0;
    int tx_gap = 0;
    int rx_stall = 0;
    bit no_idle = 1'b0;

    quoted_argument_tokenizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            CH_LOW_N: return CH_LF;
            CH_LOW_R: return CH_CR;
            CH_LOW_T: return CH_TAB;
            default:  return c;
        endcase
    endfunction

    function void tokenize_byte(input logic [7:0] c);
        result_t r;
        mode_t   nxt;
        mode_t   quote_mode;
        logic    opens;
        logic    refused;
        r = '0;
        nxt = parse_mode;
        opens = 1'b0;
        refused = 1'b0;
        if (c == CH_NUL) begin
            r.done_res = 1'b1;
            r.ends_arg = (parse_mode != MODE_SEARCH);
        end else if (string_ovf) begin
            return;
        end else if (esc_armed) begin
            esc_armed = 1'b0;
            r.has_byte = 1'b1;
            r.out_byte = unescape(c);
        end else begin
            case (c)
                CH_SQUOTE, CH_DQUOTE: begin
                    quote_mode = (c == CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                    if (parse_mode == MODE_SEARCH) begin
                        opens = 1'b1;
                        nxt = quote_mode;
                    end else if (parse_mode == quote_mode) begin
                        nxt = MODE_PLAIN;
                    end else if (parse_mode == MODE_PLAIN) begin
                        nxt = quote_mode;
                    end else begin
                        // other quote kind inside quotes is literal
                        r.has_byte = 1'b1;
                        r.out_byte = c;
                    end
                end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                    if (parse_mode == MODE_PLAIN) begin
                        r.ends_arg = 1'b1;
                        nxt = MODE_SEARCH;
                    end else if (parse_mode != MODE_SEARCH) begin
                        r.has_byte = 1'b1;
                        r.out_byte = c;
                    end
                end
                CH_BSLASH: begin
                    if (parse_mode == MODE_SEARCH) begin
                        opens = 1'b1;
                        nxt = MODE_PLAIN;
                    end
                end
                default: begin
                    if (parse_mode == MODE_SEARCH) begin
                        opens = 1'b1;
                        nxt = MODE_PLAIN;
                    end
                    r.has_byte = 1'b1;
                    r.out_byte = c;
                end
            endcase
            if (opens && word_cnt >= max_words) begin
                string_ovf = 1'b1;
                refused = 1'b1;
                r.has_byte = 1'b0;
                r.out_byte = '0;
            end else begin
                if (opens) begin
                    r.starts_arg = 1'b1;
                    word_cnt = word_cnt + 8'd1;
                end
                parse_mode = nxt;
                if (c == CH_BSLASH) esc_armed = 1'b1;
            end
        end
        if (!(r.starts_arg || r.has_byte || r.ends_arg || r.done_res || refused)) return;
        r.arg_number = word_cnt;
        r.overflow = string_ovf;
        split_results_q.push_back(r);
        if (r.done_res) begin
            parse_mode = MODE_SEARCH;
            esc_armed = 1'b0;
            word_cnt = '0;
            string_ovf = 1'b0;
        end
    endfunction

    function void check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("result %0d: %s expected 0x%0h, got 0x%0h", results_checked, name,
                   exp_v, act_v);
            errors++;
        end
    endfunction

    function void compare_result();
        result_t exp_r;
        if (split_results_q.size() == 0) begin
            $error("unexpected result: tdata 0x%h tuser 0x%h tlast %b", m_tdata, m_tuser,
                   m_tlast);
            errors++;
            return;
        end
        exp_r = split_results_q.pop_front();
        check_field("starts_arg", exp_r.starts_arg, m_tuser[0]);
        check_field("has_byte", exp_r.has_byte, m_tuser[1]);
        check_field("out_byte", exp_r.out_byte, m_tdata[7:0]);
        check_field("ends_arg", exp_r.ends_arg, m_tuser[2]);
        check_field("arg_number", exp_r.arg_number, m_tdata[15:8]);
        check_field("done_res", exp_r.done_res, m_tlast);
        check_field("overflow", exp_r.overflow, m_tuser[3]);
        results_checked++;
        if (exp_r.starts_arg) starts_seen++;
        if (exp_r.overflow && !exp_r.done_res) overflows_seen++;
    endfunction

    // Byte source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tokenize_byte(s_tdata);
                bytes_sent++;
                if (s_tdata == CH_NUL) strings_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_bytes_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= cmd_bytes_q.pop_front();
                    tx_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) compare_result();
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    task automatic push_text(input string s);
        foreach (s[i]) cmd_bytes_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    task automatic push_escape();
        cmd_bytes_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 8))
            0: cmd_bytes_q.push_back(CH_LOW_N);
            1: cmd_bytes_q.push_back(CH_LOW_R);
            2: cmd_bytes_q.push_back(CH_LOW_T);
            3: cmd_bytes_q.push_back(CH_DQUOTE);
            4: cmd_bytes_q.push_back(CH_SQUOTE);
            5: cmd_bytes_q.push_back(CH_BSLASH);
            6: cmd_bytes_q.push_back(rand_blank());
            default: cmd_bytes_q.push_back(8'($urandom_range(1, 255)));
        endcase
    endtask

    // Quoted section: letters, blanks, the other quote, escapes; the closing quote is usually pushed
    task automatic push_quoted(input logic [7:0] q);
        cmd_bytes_q.push_back(q);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 4))
                0: cmd_bytes_q.push_back(rand_blank());
                1: cmd_bytes_q.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                2: push_escape();
                default: cmd_bytes_q.push_back(rand_letter());
            endcase
        end
        if ($urandom_range(0, 9) != 0) cmd_bytes_q.push_back(q);
    endtask

    task automatic push_random_string();
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 6)) begin
            repeat ($urandom_range(0, 2)) cmd_bytes_q.push_back(rand_blank());
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 5)) cmd_bytes_q.push_back(rand_letter());
                3: push_quoted(CH_DQUOTE);
                4: push_quoted(CH_SQUOTE);
                5: begin
                    push_escape();
                    repeat ($urandom_range(0, 2)) cmd_bytes_q.push_back(rand_letter());
                end
                6: repeat ($urandom_range(1, 4)) cmd_bytes_q.push_back(8'($urandom_range(1, 255)));
                7: begin
                    cmd_bytes_q.push_back(rand_letter());
                    push_quoted($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                    cmd_bytes_q.push_back(rand_letter());
                end
                8: begin
                    cmd_bytes_q.push_back(CH_BSLASH);
                    cmd_bytes_q.push_back(rand_letter());
                end
                default: begin
                    // stray quote followed by a blank
                    cmd_bytes_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                    cmd_bytes_q.push_back(rand_blank());
                end
            endcase
        end
        if ($urandom_range(0, 15) == 0) cmd_bytes_q.push_back(CH_BSLASH);
        cmd_bytes_q.push_back(CH_NUL);
    endtask

    // Sender holds off until every result is back, then allows for quiet bytes in flight
    task automatic wait_drained();
        do @(negedge aclk);
        while (cmd_bytes_q.size() != 0 || s_tvalid || split_results_q.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_max_args(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_words = v;
    endtask

    initial begin
        int phase;
        int phase_start;
        int random_bytes;
        logic [7:0] setting;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Blanks while searching, 0x01/0xFF word, quote toggles, escapes,
        // unterminated single quote with a backslash right before the end
        push_text(" \t");
        cmd_bytes_q.push_back(CH_CR);
        cmd_bytes_q.push_back(CH_LF);
        cmd_bytes_q.push_back(8'h01);
        cmd_bytes_q.push_back(8'hFF);
        push_text("\"a' \"\\n\\t\\r\\\\ 'x\"\\");
        cmd_bytes_q.push_back(CH_NUL);
        wait_drained();

        // Word limit of one: refused starts, dropped tail, backslash opening a word
        write_max_args(8'd1);
        push_text("a b 'd'");
        cmd_bytes_q.push_back(CH_NUL);
        push_text("\\qa z");
        cmd_bytes_q.push_back(CH_NUL);
        push_text("'' x");
        cmd_bytes_q.push_back(CH_NUL);
        wait_drained();

        // Largest limit: 255 words accepted, the next one refused
        write_max_args(8'd255);
        repeat (256) push_text("a ");
        cmd_bytes_q.push_back(CH_NUL);
        wait_drained();

        random_bytes = 0;
        phase = 0;
        while (random_bytes < 300) begin
            case (phase % 6)
                0: setting = 8'd2;
                1: setting = MAX_ARGS_RESET;
                2: setting = 8'd1;
                3: setting = 8'd255;
                4: setting = 8'($urandom_range(3, 10));
                default: setting = 8'($urandom_range(1, 255));
            endcase
            write_max_args(setting);
            no_idle = (phase % 3 == 2);
            phase_start = cmd_bytes_q.size();
            while (cmd_bytes_q.size() - phase_start < 50) push_random_string();
            random_bytes += cmd_bytes_q.size() - phase_start;
            wait_drained();
            phase++;
        end

        $display("Covered %0d bytes in %0d strings over %0d limit settings;", bytes_sent,
                 strings_sent, phase + 3);
        $display("checked %0d results, %0d word starts, %0d refused starts.",
                 results_checked, starts_seen, overflows_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
